// ----- src/dtn_pkg.sv -----
// ----------------------------------------------------------------------------
// dtn_pkg
// Shared widths, control types and constants for the dual top-N tracker.
// ----------------------------------------------------------------------------
package dtn_pkg;

    localparam int SCORE_W   = 15;   // score field, unsigned fixed point 7.8
    localparam int TAG_W     = 16;   // tag field on the ports
    localparam int CNT_W     = 6;    // fill counts, rank, top_count
    localparam int IN_DATA_W  = 32;  // score + tag, padded to bytes
    localparam int OUT_DATA_W = 40;  // rank + score + tag, padded to bytes

    localparam logic [CNT_W-1:0] TOP_COUNT_RST = 6'd10;

    localparam logic LIST_LOW  = 1'b0;
    localparam logic LIST_HIGH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'b001,
        ST_RD_LOW  = 3'b010,
        ST_RD_HIGH = 3'b100
    } dtn_state_t;

    // controller -> datapath
    typedef struct packed {
        logic ins;       // insert accepted item into both lists
        logic cnt_clr;   // restart readout counter
        logic rd_low;    // load one low-list beat into the output register
        logic rd_high;   // load one high-list beat into the output register
        logic clr_fill;  // empty both lists
    } dtn_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic low_done;  // readout counter reached low fill
        logic high_done; // readout counter reached high fill
        logic out_free;  // output register can take a beat this cycle
    } dtn_stat_t;

endpackage

// ----- src/dtn_ctrl.sv -----
// ----------------------------------------------------------------------------
// dtn_ctrl
// Sequencer: accepts items, then walks the low and high lists on readout.
// ----------------------------------------------------------------------------
module dtn_ctrl
    import dtn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    input  logic      s_tlast,
    output logic      s_tready,
    input  dtn_stat_t stat,
    output dtn_cmd_t  cmd
);

    dtn_state_t state_reg;
    dtn_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.ins = 1'b1;
                    if (s_tlast)
                    begin
                        cmd.cnt_clr = 1'b1;
                        state_next  = ST_RD_LOW;
                    end
                end
            end
            ST_RD_LOW:
            begin
                if (stat.low_done)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_RD_HIGH;
                end
                else if (stat.out_free)
                begin
                    cmd.rd_low = 1'b1;
                end
            end
            ST_RD_HIGH:
            begin
                if (stat.high_done)
                begin
                    cmd.clr_fill = 1'b1;
                    state_next   = ST_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.rd_high = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- src/dtn_dp.sv -----
// ----------------------------------------------------------------------------
// dtn_dp
// List registers with parallel compare/shift insert, readout counter and
// output register.
// ----------------------------------------------------------------------------
module dtn_dp
    import dtn_pkg::*;
#(
    parameter int MAX_KEEP = 32,
    parameter int TAG_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [SCORE_W-1:0]    score,
    input  logic [TAG_W-1:0]      item_tag,
    input  logic                  cfg_we,
    input  logic [CNT_W-1:0]      cfg_wdata,
    input  dtn_cmd_t              cmd,
    output dtn_stat_t             stat,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  out_list,
    output logic [CNT_W-1:0]      out_rank,
    output logic [SCORE_W-1:0]    out_score,
    output logic [TAG_W-1:0]      out_tag,
    output logic                  out_last
);

    localparam int KEEP_TAG_W = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
    localparam int IDX_W      = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam logic [CNT_W-1:0] KEEP_MAX = CNT_W'(MAX_KEEP);

    logic [SCORE_W-1:0]    low_sc_reg  [MAX_KEEP];
    logic [KEEP_TAG_W-1:0] low_tg_reg  [MAX_KEEP];
    logic [SCORE_W-1:0]    high_sc_reg [MAX_KEEP];
    logic [KEEP_TAG_W-1:0] high_tg_reg [MAX_KEEP];
    logic [SCORE_W-1:0]    low_sc_next [MAX_KEEP];
    logic [KEEP_TAG_W-1:0] low_tg_next [MAX_KEEP];
    logic [SCORE_W-1:0]    high_sc_next[MAX_KEEP];
    logic [KEEP_TAG_W-1:0] high_tg_next[MAX_KEEP];

    logic [CNT_W-1:0] low_fill_reg, low_fill_next;
    logic [CNT_W-1:0] high_fill_reg, high_fill_next;
    logic [CNT_W-1:0] top_count_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  out_list_reg, out_last_reg;
    logic [CNT_W-1:0]      out_rank_reg;
    logic [SCORE_W-1:0]    out_score_reg;
    logic [KEEP_TAG_W-1:0] out_tag_reg;

    logic [CNT_W-1:0]      lim;
    logic                  low_open, high_open;
    logic [MAX_KEEP-1:0]   low_gt, low_win, high_gt, high_lt, high_win;
    logic [KEEP_TAG_W-1:0] tag_in;
    logic [IDX_W-1:0]      low_idx, high_idx;
    logic [CNT_W-1:0]      high_pos;

    assign tag_in    = item_tag[KEEP_TAG_W-1:0];
    assign lim       = (top_count_reg > KEEP_MAX) ? KEEP_MAX : top_count_reg;
    assign low_open  = low_fill_reg < lim;
    assign high_open = high_fill_reg < lim;

    // per-entry compares; valid entries form a sorted prefix
    always_comb
    begin
        for (int i = 0; i < MAX_KEEP; i++)
        begin
            low_gt[i]   = (CNT_W'(i) < low_fill_reg) && (low_sc_reg[i] > score);
            high_gt[i]  = (CNT_W'(i) < high_fill_reg) && (high_sc_reg[i] > score);
            high_lt[i]  = (CNT_W'(i) < high_fill_reg) && (high_sc_reg[i] < score);
            low_win[i]  = low_open ? (CNT_W'(i) <= low_fill_reg)
                                   : (CNT_W'(i) < low_fill_reg);
            high_win[i] = CNT_W'(i) <= high_fill_reg;
        end
    end

    // low list: insert after equal scores, push larger ones right
    always_comb
    begin
        for (int i = 0; i < MAX_KEEP; i++)
        begin
            low_sc_next[i] = low_sc_reg[i];
            low_tg_next[i] = low_tg_reg[i];
            if (low_win[i] && (low_gt[i] || (low_open && CNT_W'(i) == low_fill_reg)))
            begin
                low_sc_next[i] = score;
                low_tg_next[i] = tag_in;
            end
        end
        for (int i = 1; i < MAX_KEEP; i++)
        begin
            if (low_win[i] && low_gt[i-1])
            begin
                low_sc_next[i] = low_sc_reg[i-1];
                low_tg_next[i] = low_tg_reg[i-1];
            end
        end
    end

    // high list: same insert while open; when full, drop entry 0 and
    // slide smaller entries left to make room
    always_comb
    begin
        for (int i = 0; i < MAX_KEEP; i++)
        begin
            high_sc_next[i] = high_sc_reg[i];
            high_tg_next[i] = high_tg_reg[i];
            if (high_open)
            begin
                if (high_win[i] && (high_gt[i] || CNT_W'(i) == high_fill_reg))
                begin
                    high_sc_next[i] = score;
                    high_tg_next[i] = tag_in;
                end
            end
            else if (high_lt[i])
            begin
                high_sc_next[i] = score;
                high_tg_next[i] = tag_in;
            end
        end
        for (int i = 1; i < MAX_KEEP; i++)
        begin
            if (high_open && high_win[i] && high_gt[i-1])
            begin
                high_sc_next[i] = high_sc_reg[i-1];
                high_tg_next[i] = high_tg_reg[i-1];
            end
        end
        for (int i = 0; i < MAX_KEEP - 1; i++)
        begin
            if (!high_open && high_lt[i] && high_lt[i+1])
            begin
                high_sc_next[i] = high_sc_reg[i+1];
                high_tg_next[i] = high_tg_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ins)
        begin
            for (int i = 0; i < MAX_KEEP; i++)
            begin
                low_sc_reg[i]  <= low_sc_next[i];
                low_tg_reg[i]  <= low_tg_next[i];
                high_sc_reg[i] <= high_sc_next[i];
                high_tg_reg[i] <= high_tg_next[i];
            end
        end
    end

    always_comb
    begin
        low_fill_next  = low_fill_reg;
        high_fill_next = high_fill_reg;
        if (cmd.clr_fill)
        begin
            low_fill_next  = '0;
            high_fill_next = '0;
        end
        else if (cmd.ins)
        begin
            low_fill_next  = low_fill_reg + CNT_W'(low_open);
            high_fill_next = high_fill_reg + CNT_W'(high_open);
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_clr)
        begin
            cnt_next = '0;
        end
        else if (cmd.rd_low || cmd.rd_high)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    // readout addressing: low ascending, high from the top down
    assign high_pos = high_fill_reg - 1'b1 - cnt_reg;
    assign low_idx  = cnt_reg[IDX_W-1:0];
    assign high_idx = high_pos[IDX_W-1:0];

    always_comb
    begin
        stat.low_done  = cnt_reg == low_fill_reg;
        stat.high_done = cnt_reg == high_fill_reg;
        stat.out_free  = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.rd_low || cmd.rd_high)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_fill_reg  <= '0;
            high_fill_reg <= '0;
            top_count_reg <= TOP_COUNT_RST;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            low_fill_reg  <= low_fill_next;
            high_fill_reg <= high_fill_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                top_count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_low)
        begin
            out_list_reg  <= LIST_LOW;
            out_rank_reg  <= cnt_reg + 1'b1;
            out_score_reg <= low_sc_reg[low_idx];
            out_tag_reg   <= low_tg_reg[low_idx];
            out_last_reg  <= (cnt_reg == low_fill_reg - 1'b1) && (high_fill_reg == '0);
        end
        else if (cmd.rd_high)
        begin
            out_list_reg  <= LIST_HIGH;
            out_rank_reg  <= cnt_reg + 1'b1;
            out_score_reg <= high_sc_reg[high_idx];
            out_tag_reg   <= high_tg_reg[high_idx];
            out_last_reg  <= cnt_reg == high_fill_reg - 1'b1;
        end
    end

    always_comb
    begin
        out_tag                   = '0;
        out_tag[KEEP_TAG_W-1:0]   = out_tag_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_list  = out_list_reg;
    assign out_rank  = out_rank_reg;
    assign out_score = out_score_reg;
    assign out_last  = out_last_reg;

endmodule

// ----- src/dual_top_n_score_tracker_unit.sv -----
// ----------------------------------------------------------------------------
// dual_top_n_score_tracker_unit
// Keeps the N lowest and N highest tagged scores of a set and reads them out.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one beat per scored item. s_tdata = {tag, score}, s_tlast
//   marks the final item of a set. Every beat goes into both sorted lists
//   (register rows with a parallel compare/shift insert) at the edge it is
//   accepted, so non-final items stream at one beat per cycle.
//   The s_tlast beat is inserted first, then s_tready drops while the lists
//   are read out on m_*: low list ascending (m_tuser = 0), then high list
//   descending (m_tuser = 1), rank 1 first; m_tlast flags the final beat.
//   With m_tready high, s_tready stays low for the readout of every entry
//   plus a turn state at the end of each list, so m_tvalid drops between
//   the lists. Both lists are empty afterwards; if both were empty nothing
//   is sent. m_* has an output register: a stall on
//   m_tready holds the beat and pauses the readout walk for as long, nothing
//   is lost or repeated. s_tready comes back while the last beat still waits.
//   cfg_we/cfg_wdata write top_count (entries kept per list, capped at
//   MAX_KEEP); write it only while s_tready is high.
//   Reset (rst_n, async low): lists empty, top_count = 10, m_tvalid low.
// ----------------------------------------------------------------------------
module dual_top_n_score_tracker_unit
    import dtn_pkg::*;
#(
    parameter int MAX_KEEP = 32,
    parameter int TAG_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [14:0] score, [30:15] item_tag, [31] zero
    input  logic                  s_tlast,   // last_item
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [5:0] rank, [20:6] score_out,
                                             // [36:21] tag_out, [39:37] zero
    output logic [0:0]            m_tuser,   // which_list
    output logic                  m_tlast,   // last_result
    input  logic                  cfg_we,
    input  logic [CNT_W-1:0]      cfg_wdata  // top_count
);

    dtn_cmd_t  cmd;
    dtn_stat_t stat;

    logic                 out_list;
    logic [CNT_W-1:0]     out_rank;
    logic [SCORE_W-1:0]   out_score;
    logic [TAG_W-1:0]     out_tag;

    // sequencer: idle/insert, low readout, high readout
    dtn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // list rows, readout counter, output register
    dtn_dp #(
        .MAX_KEEP (MAX_KEEP),
        .TAG_BITS (TAG_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .score     (s_tdata[SCORE_W-1:0]),
        .item_tag  (s_tdata[SCORE_W+TAG_W-1:SCORE_W]),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_list  (out_list),
        .out_rank  (out_rank),
        .out_score (out_score),
        .out_tag   (out_tag),
        .out_last  (m_tlast)
    );

    assign m_tdata = {(OUT_DATA_W-CNT_W-SCORE_W-TAG_W)'(0), out_tag, out_score, out_rank};
    assign m_tuser = out_list;

endmodule

// ----- tb/sv/dual_top_n_score_tracker_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_top_n_score_tracker_unit_test
// Self-checking bench for the dual top-N score tracker. Scored beats are fed
// from a queue by a clocked driver. A model of both sorted lists predicts the
// readout of every set, and a clocked monitor checks each m_* beat against
// it. Both sides idle in random bursts. top_count is changed between sets and
// also in the middle of a set, including zero and values above the cap.
// ----------------------------------------------------------------------------
module dual_top_n_score_tracker_unit_test;
    import dtn_pkg::*;

    localparam int KEEP_CAP     = 32;    // MAX_KEEP of the instance
    localparam int TOP_NONE     = 0;     // lists do not grow
    localparam int TOP_ONE      = 1;
    localparam int TOP_FULL     = 32;
    localparam int TOP_ALL_ONES = 63;    // saturates at KEEP_CAP
    localparam int SCORE_TOP    = 25600; // 100.0 in 7.8 fixed point
    localparam int RANDOM_ITEMS = 80;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT  = 2000;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [TAG_W-1:0]   tag;
        logic               last;
    } score_beat_t;

    typedef struct packed {
        logic               list_sel;
        logic [CNT_W-1:0]   rank;
        logic [SCORE_W-1:0] score;
        logic [TAG_W-1:0]   tag;
        logic               last;
    } entry_beat_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [0:0]            m_tuser;
    logic                  m_tlast;
    logic                  cfg_we = 1'b0;
    logic [CNT_W-1:0]      cfg_wdata = '0;

    // pending input beats and expected readout beats
    score_beat_t score_feed [$];
    entry_beat_t readout_q [$];

    // list model: rows ascending by score, indexed by LIST_LOW / LIST_HIGH
    logic [SCORE_W-1:0] kept_score [2][KEEP_CAP];
    logic [TAG_W-1:0]   kept_tag   [2][KEEP_CAP];
    int                 kept_fill  [2] = '{0, 0};
    int                 keep_limit = TOP_COUNT_RST;

    int  mismatch_count = 0;
    bit  quiet = 1'b0;       // no idling on either side
    int  feed_gap = 0;
    int  feed_run = 0;
    int  sink_gap = 0;
    int  sink_run = 0;
    int  idle_cycles = 0;
    score_beat_t next_beat;
    entry_beat_t want_beat;

    dual_top_n_score_tracker_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // place s/t at pos, then move it forward past strictly larger scores;
    // equal scores keep arrival order
    function automatic void sift_in(input logic lst, input int pos,
                                    input logic [SCORE_W-1:0] s,
                                    input logic [TAG_W-1:0] t);
        int p;
        p = pos;
        while (p > 0 && kept_score[lst][p-1] > s)
        begin
            kept_score[lst][p] = kept_score[lst][p-1];
            kept_tag[lst][p]   = kept_tag[lst][p-1];
            p--;
        end
        kept_score[lst][p] = s;
        kept_tag[lst][p]   = t;
    endfunction

    // update both lists with one accepted beat; on the set's last beat queue
    // the readout and empty the lists
    function automatic void track_score(input logic [SCORE_W-1:0] s,
                                        input logic [TAG_W-1:0] t,
                                        input logic is_last);
        int lim;
        int pos;
        int total;
        int emitted;
        int idx;
        entry_beat_t e;
        lim = (keep_limit > KEEP_CAP) ? KEEP_CAP : keep_limit;

        // low list: worst entry is the last one
        if (kept_fill[LIST_LOW] < lim)
        begin
            sift_in(LIST_LOW, kept_fill[LIST_LOW], s, t);
            kept_fill[LIST_LOW]++;
        end
        else if (kept_fill[LIST_LOW] > 0 && s < kept_score[LIST_LOW][kept_fill[LIST_LOW]-1])
            sift_in(LIST_LOW, kept_fill[LIST_LOW] - 1, s, t);

        // high list: worst entry is the first one, new entry walks upward
        if (kept_fill[LIST_HIGH] < lim)
        begin
            sift_in(LIST_HIGH, kept_fill[LIST_HIGH], s, t);
            kept_fill[LIST_HIGH]++;
        end
        else if (kept_fill[LIST_HIGH] > 0 && s > kept_score[LIST_HIGH][0])
        begin
            pos = 0;
            while (pos + 1 < kept_fill[LIST_HIGH] && kept_score[LIST_HIGH][pos+1] < s)
            begin
                kept_score[LIST_HIGH][pos] = kept_score[LIST_HIGH][pos+1];
                kept_tag[LIST_HIGH][pos]   = kept_tag[LIST_HIGH][pos+1];
                pos++;
            end
            kept_score[LIST_HIGH][pos] = s;
            kept_tag[LIST_HIGH][pos]   = t;
        end

        if (!is_last)
            return;

        total   = kept_fill[LIST_LOW] + kept_fill[LIST_HIGH];
        emitted = 0;
        for (int lst = 0; lst < 2; lst++)
        begin
            for (int i = 0; i < kept_fill[lst]; i++)
            begin
                // low list ascending, high list descending
                idx = (lst == LIST_LOW) ? i : kept_fill[lst] - 1 - i;
                e.list_sel = (lst == LIST_LOW) ? LIST_LOW : LIST_HIGH;
                e.rank     = CNT_W'(i + 1);
                e.score    = kept_score[lst][idx];
                e.tag      = kept_tag[lst][idx];
                e.last     = (emitted == total - 1);
                readout_q  = {readout_q, e};
                emitted++;
            end
        end
        kept_fill[LIST_LOW]  = 0;
        kept_fill[LIST_HIGH] = 0;
    endfunction

    function automatic int beat_field_bad(input string name, input int want, input int got);
        if (want == got)
            return 0;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        return 1;
    endfunction

    function automatic void feed(input int s, input int t, input bit is_last);
        score_beat_t b;
        b.score = s[SCORE_W-1:0];
        b.tag   = t[TAG_W-1:0];
        b.last  = is_last;
        score_feed = {score_feed, b};
    endfunction

    // mix of tie clusters near both ends, the legal range and the full field
    function automatic int pick_score();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 7);
            1:       return SCORE_TOP - $urandom_range(0, 7);
            2:       return $urandom_range(1000, 1003);
            3:       return $urandom_range(0, (1 << SCORE_W) - 1);
            default: return $urandom_range(0, SCORE_TOP);
        endcase
    endfunction

    function automatic int pick_limit();
        case ($urandom_range(0, 6))
            0:       return TOP_ONE;
            1:       return TOP_FULL;
            2:       return TOP_ALL_ONES;
            3:       return $urandom_range(KEEP_CAP + 1, TOP_ALL_ONES - 1);
            4:       return TOP_NONE;
            default: return $urandom_range(2, KEEP_CAP - 1);
        endcase
    endfunction

    // all beats sent, readout walk done and all readout seen; sampled on the
    // falling edge so the clocked blocks have settled
    task automatic wait_idle();
        @(negedge clk);
        while (!(score_feed.size() == 0 && !s_tvalid && readout_q.size() == 0
                 && s_tready && !m_tvalid))
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_top_count(input int v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v[CNT_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        keep_limit = v;
    endtask

    // driver: holds a beat until taken, otherwise sends the next one or idles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                track_score(s_tdata[SCORE_W-1:0], s_tdata[SCORE_W+TAG_W-1:SCORE_W], s_tlast);
            if (!s_tvalid || s_tready)
            begin
                if (feed_gap > 0)
                begin
                    feed_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (score_feed.size() == 0)
                    s_tvalid <= 1'b0;
                else if (!quiet && feed_run == 0 && $urandom_range(0, 3) == 0)
                begin
                    feed_gap = $urandom_range(0, 16);
                    feed_run = $urandom_range(0, 30);
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    next_beat = score_feed.pop_front();
                    s_tdata  <= {1'b0, next_beat.tag, next_beat.score};
                    s_tlast  <= next_beat.last;
                    s_tvalid <= 1'b1;
                    if (feed_run > 0)
                        feed_run--;
                end
            end
        end
    end

    // monitor: checks each readout beat and stalls m_tready in bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (readout_q.size() == 0)
                begin
                    $display({"%0t: unexpected beat, expected none actual list %0d",
                              " rank %0d score %0d tag %0d last %0d"},
                             $time, m_tuser[0], m_tdata[5:0], m_tdata[20:6],
                             m_tdata[36:21], m_tlast);
                    mismatch_count++;
                end
                else
                begin
                    want_beat = readout_q.pop_front();
                    mismatch_count += beat_field_bad("which_list", want_beat.list_sel, m_tuser[0]);
                    mismatch_count += beat_field_bad("rank", want_beat.rank, m_tdata[5:0]);
                    mismatch_count += beat_field_bad("score_out", want_beat.score, m_tdata[20:6]);
                    mismatch_count += beat_field_bad("tag_out", want_beat.tag, m_tdata[36:21]);
                    mismatch_count += beat_field_bad("last_result", want_beat.last, m_tlast);
                end
            end
            if (sink_gap > 0)
            begin
                sink_gap--;
                m_tready <= 1'b0;
            end
            else if (!quiet && sink_run == 0 && $urandom_range(0, 3) == 0)
            begin
                sink_gap = $urandom_range(0, 16);
                sink_run = $urandom_range(0, 30);
                m_tready <= 1'b0;
            end
            else
            begin
                if (sink_run > 0)
                    sink_run--;
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no beat and no register write
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("FAIL dual_top_n_score_tracker_unit");
                $finish;
            end
        end
    end

    initial
    begin
        int  fed_random;
        int  set_len;
        bit  leave_open;
        fed_random = 0;
        leave_open = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // three entries per list: ties keep arrival order, equal score does
        // not replace, field extremes
        write_top_count(3);
        feed(100, 'h0001, 0);
        feed(100, 'h0002, 0);
        feed(50, 'h0003, 0);
        feed(100, 'h0004, 0);
        feed(0, 'h0000, 0);
        feed((1 << SCORE_W) - 1, 'hFFFF, 0);
        feed(SCORE_TOP, 'h5555, 1);
        wait_idle();

        // zero limit on empty lists: readout sends nothing
        write_top_count(TOP_NONE);
        feed(500, 'h1234, 1);
        wait_idle();

        // single entry lists
        write_top_count(TOP_ONE);
        feed(7, 'h00AA, 0);
        feed(7, 'h00BB, 0);
        feed(6, 'h00CC, 0);
        feed(8, 'h00DD, 1);
        wait_idle();

        // limit lowered mid-set, then zero: held entries still get replaced
        write_top_count(TOP_FULL);
        feed(300, 'h0101, 0);
        feed(200, 'h0202, 0);
        feed(400, 'h0303, 0);
        feed(200, 'h0404, 0);
        feed(100, 'h0505, 0);
        wait_idle();
        write_top_count(2);
        feed(150, 'h0606, 0);
        feed(450, 'h0707, 0);
        wait_idle();
        write_top_count(TOP_NONE);
        feed(50, 'h0808, 0);
        feed(500, 'h0909, 1);
        wait_idle();

        // limit above the cap with a set longer than the cap
        write_top_count(TOP_ALL_ONES);
        for (int i = 0; i < 36; i++)
            feed(pick_score(), $urandom, i == 35);
        fed_random += 36;

        while (fed_random < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                wait_idle();
                write_top_count(pick_limit());
            end
            if (fed_random >= RANDOM_ITEMS - 20)
                quiet = 1'b1;
            set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(KEEP_CAP + 1, 40)
                                                  : $urandom_range(1, 12);
            // some sets run on without a last beat into the next setting
            leave_open = ($urandom_range(0, 5) == 0);
            for (int i = 0; i < set_len; i++)
                feed(pick_score(), $urandom, (i == set_len - 1) && !leave_open);
            fed_random += set_len;
        end
        if (leave_open)
            feed(pick_score(), $urandom, 1);

        wait_idle();
        if (mismatch_count == 0 && readout_q.size() == 0)
            $display("PASS dual_top_n_score_tracker_unit");
        else
            $display("FAIL dual_top_n_score_tracker_unit");
        $finish;
    end

endmodule
